/* hw/rtl/adcfcc_pkg.sv */
// Shared constants and CRC helper for the ADC frame CRC checker.
package adcfcc_pkg;

    localparam int CHANNELS_DEF = 8;

    // configuration register indexes
    localparam logic [0:0] REG_LAST_CHANNEL = 1'b0;
    localparam logic [0:0] REG_CRC_MODE     = 1'b1;

    localparam logic [2:0] LAST_CHANNEL_RST = 3'd7;
    localparam logic       CRC_MODE_RST     = 1'b1;

    localparam logic [7:0] CRC_POLY  = 8'h07;
    localparam int         DIGIT_W   = 4;

    // output word: channel, sample_a, sample_b, good_frames, bad_frames, pad
    localparam int OUT_FIELDS_W = 3 + 16 + 16 + 32 + 32;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    // CRC-8 advanced by one nibble, MSB first
    function automatic logic [7:0] crc8_nibble(input logic [7:0] crc_in,
                                               input logic [DIGIT_W-1:0] nib);
        logic [7:0] c;
        logic       fb;
        c = crc_in;
        for (int k = DIGIT_W - 1; k >= 0; k--)
        begin
            fb = c[7] ^ nib[k];
            c  = {c[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
        end
        return c;
    endfunction

endpackage

/* hw/rtl/adc_frame_crc_checker.sv */
// ADC frame CRC checker: byte assembly, nibble-serial CRC-8 walk, per-channel results.
// After the frame's final byte, CRC mode runs a 4-bit-per-cycle CRC walk over the A then
// B words of all CHANNELS channels and a check state, plain mode one copy state; then
// CHANNELS result words leave at one per cycle while m_tready allows. Throughput: one
// byte per cycle inside a frame; none from the frame end until the last result is queued.
// Reset (rst_n, async low): counters, stored samples and position cleared,
// last_channel = 7, crc_mode = 1.
module adc_frame_crc_checker #(
    parameter int CHANNELS = adcfcc_pkg::CHANNELS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // configuration write port
    input  logic                               wr_en,
    input  logic [0:0]                         wr_index,
    input  logic [2:0]                         wr_data,
    // byte stream in
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [7:0]                         s_tdata,  // [7:0] rx_byte
    input  logic [0:0]                         s_tuser,  // [0] frame_start
    // result stream out
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [2:0] channel, [18:3] sample_a, [34:19] sample_b, [66:35] good_frames,
    // [98:67] bad_frames, rest zero
    output logic [adcfcc_pkg::OUT_TDATA_W-1:0] m_tdata,
    output logic [0:0]                         m_tuser,  // [0] data_valid
    output logic                               m_tlast
);

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [CH_W-1:0] CH_LAST = CH_W'(CHANNELS - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_CHECK,
        ST_PLAIN,
        ST_EMIT
    } state_t;

    state_t             state_reg, state_next;
    logic [2:0]         last_channel_reg, last_channel_next;
    logic               crc_mode_reg, crc_mode_next;
    logic [5:0]         pos_reg, pos_next;
    logic [15:0]        pend_a_reg [CHANNELS], pend_a_next [CHANNELS];
    logic [15:0]        pend_b_reg [CHANNELS], pend_b_next [CHANNELS];
    logic [15:0]        pub_a_reg [CHANNELS], pub_a_next [CHANNELS];
    logic [15:0]        pub_b_reg [CHANNELS], pub_b_next [CHANNELS];
    logic               frame_ok_reg, frame_ok_next;
    logic [31:0]        good_reg, good_next;
    logic [31:0]        bad_reg, bad_next;
    logic [7:0]         rx_crc_reg, rx_crc_next;
    logic [7:0]         crc_reg, crc_next;
    logic [11:0]        sh_reg, sh_next;      // remaining nibbles of the current word
    logic [1:0]         digit_reg, digit_next;
    logic               side_reg, side_next;  // 0 = A words, 1 = B words
    logic [CH_W-1:0]    idx_reg, idx_next;    // walk and emit channel
    logic               m_valid_reg, m_valid_next;
    logic [adcfcc_pkg::OUT_TDATA_W-1:0] m_data_reg, m_data_next;
    logic               m_user_reg, m_user_next;
    logic               m_last_reg, m_last_next;

    // byte decode
    logic [5:0]  pos;
    logic [3:0]  nch;
    logic [5:0]  data_len;
    logic [5:0]  end_pos;
    logic [2:0]  byte_ch;
    logic        byte_hi;
    logic        byte_side;
    logic        byte_wr;
    logic [15:0] walk_word;
    logic [3:0]  walk_nib;
    logic        take;

    assign take      = s_tvalid && s_tready;
    assign pos       = s_tuser[0] ? 6'd0 : pos_reg;
    assign nch       = {1'b0, last_channel_reg} + 4'd1;
    assign data_len  = {nch, 2'b00};
    assign end_pos   = crc_mode_reg ? data_len : data_len - 6'd1;
    assign byte_ch   = pos[4:2];
    assign byte_side = pos[1];
    // CRC mode is little-endian, plain mode big-endian
    assign byte_hi   = crc_mode_reg ? pos[0] : !pos[0];
    assign byte_wr   = (pos < data_len) && (32'(byte_ch) < CHANNELS);

    assign walk_word = side_reg ? pend_b_reg[idx_reg] : pend_a_reg[idx_reg];
    assign walk_nib  = (digit_reg == 2'd0) ? walk_word[15:12] : sh_reg[11:8];

    always_comb
    begin
        state_next        = state_reg;
        last_channel_next = last_channel_reg;
        crc_mode_next     = crc_mode_reg;
        pos_next          = pos_reg;
        pend_a_next       = pend_a_reg;
        pend_b_next       = pend_b_reg;
        pub_a_next        = pub_a_reg;
        pub_b_next        = pub_b_reg;
        frame_ok_next     = frame_ok_reg;
        good_next         = good_reg;
        bad_next          = bad_reg;
        rx_crc_next       = rx_crc_reg;
        crc_next          = crc_reg;
        sh_next           = sh_reg;
        digit_next        = digit_reg;
        side_next         = side_reg;
        idx_next          = idx_reg;
        m_valid_next      = m_valid_reg;
        m_data_next       = m_data_reg;
        m_user_next       = m_user_reg;
        m_last_next       = m_last_reg;

        if (wr_en)
        begin
            case (wr_index)
                adcfcc_pkg::REG_LAST_CHANNEL: last_channel_next = wr_data;
                adcfcc_pkg::REG_CRC_MODE:     crc_mode_next     = wr_data[0];
                default:                      ;
            endcase
        end

        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    if (pos == 6'd0)
                    begin
                        for (int i = 0; i < CHANNELS; i++)
                        begin
                            pend_a_next[i] = '0;
                            pend_b_next[i] = '0;
                        end
                    end
                    if (byte_wr)
                    begin
                        for (int i = 0; i < CHANNELS; i++)
                        begin
                            if (32'(byte_ch) == i)
                            begin
                                if (!byte_side && byte_hi)
                                    pend_a_next[i][15:8] = s_tdata;
                                if (!byte_side && !byte_hi)
                                    pend_a_next[i][7:0] = s_tdata;
                                if (byte_side && byte_hi)
                                    pend_b_next[i][15:8] = s_tdata;
                                if (byte_side && !byte_hi)
                                    pend_b_next[i][7:0] = s_tdata;
                            end
                        end
                    end
                    if (pos < end_pos)
                    begin
                        pos_next = pos + 6'd1;
                    end
                    else
                    begin
                        pos_next    = 6'd0;
                        rx_crc_next = s_tdata;
                        idx_next    = '0;
                        if (crc_mode_reg)
                        begin
                            state_next = ST_WALK;
                            crc_next   = 8'h00;
                            digit_next = 2'd0;
                            side_next  = 1'b0;
                        end
                        else
                        begin
                            state_next = ST_PLAIN;
                        end
                    end
                end
            end

            ST_WALK:
            begin
                crc_next   = adcfcc_pkg::crc8_nibble(crc_reg, walk_nib);
                sh_next    = (digit_reg == 2'd0) ? walk_word[11:0] : {sh_reg[7:0], 4'h0};
                digit_next = digit_reg + 2'd1;
                if (digit_reg == 2'd3)
                begin
                    if (idx_reg == CH_LAST)
                    begin
                        idx_next  = '0;
                        side_next = 1'b1;
                        if (side_reg)
                            state_next = ST_CHECK;
                    end
                    else
                    begin
                        idx_next = idx_reg + CH_W'(1);
                    end
                end
            end

            ST_CHECK:
            begin
                if (crc_reg == rx_crc_reg)
                begin
                    pub_a_next    = pend_a_reg;
                    pub_b_next    = pend_b_reg;
                    frame_ok_next = 1'b1;
                    good_next     = good_reg + 32'd1;
                end
                else
                begin
                    frame_ok_next = 1'b0;
                    bad_next      = bad_reg + 32'd1;
                end
                state_next = ST_EMIT;
            end

            ST_PLAIN:
            begin
                // only scanned channels are published
                for (int i = 0; i < CHANNELS; i++)
                begin
                    if (i <= int'(last_channel_reg))
                    begin
                        pub_a_next[i] = pend_a_reg[i];
                        pub_b_next[i] = pend_b_reg[i];
                    end
                end
                frame_ok_next = 1'b1;
                state_next    = ST_EMIT;
            end

            ST_EMIT:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = '0;
                    m_data_next[2:0]   = 3'(idx_reg);
                    m_data_next[18:3]  = pub_a_reg[idx_reg];
                    m_data_next[34:19] = pub_b_reg[idx_reg];
                    m_data_next[66:35] = good_reg;
                    m_data_next[98:67] = bad_reg;
                    m_user_next  = frame_ok_reg;
                    m_last_next  = (idx_reg == CH_LAST);
                    if (idx_reg == CH_LAST)
                    begin
                        idx_next   = '0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + CH_W'(1);
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            last_channel_reg <= adcfcc_pkg::LAST_CHANNEL_RST;
            crc_mode_reg     <= adcfcc_pkg::CRC_MODE_RST;
            pos_reg          <= '0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                pend_a_reg[i] <= '0;
                pend_b_reg[i] <= '0;
                pub_a_reg[i]  <= '0;
                pub_b_reg[i]  <= '0;
            end
            frame_ok_reg     <= 1'b0;
            good_reg         <= '0;
            bad_reg          <= '0;
            rx_crc_reg       <= '0;
            crc_reg          <= '0;
            sh_reg           <= '0;
            digit_reg        <= '0;
            side_reg         <= 1'b0;
            idx_reg          <= '0;
            m_valid_reg      <= 1'b0;
            m_data_reg       <= '0;
            m_user_reg       <= 1'b0;
            m_last_reg       <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            last_channel_reg <= last_channel_next;
            crc_mode_reg     <= crc_mode_next;
            pos_reg          <= pos_next;
            pend_a_reg       <= pend_a_next;
            pend_b_reg       <= pend_b_next;
            pub_a_reg        <= pub_a_next;
            pub_b_reg        <= pub_b_next;
            frame_ok_reg     <= frame_ok_next;
            good_reg         <= good_next;
            bad_reg          <= bad_next;
            rx_crc_reg       <= rx_crc_next;
            crc_reg          <= crc_next;
            sh_reg           <= sh_next;
            digit_reg        <= digit_next;
            side_reg         <= side_next;
            idx_reg          <= idx_next;
            m_valid_reg      <= m_valid_next;
            m_data_reg       <= m_data_next;
            m_user_reg       <= m_user_next;
            m_last_reg       <= m_last_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

    // byte position never runs past the CRC byte of the longest frame
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= 6'd32)
        else $error("byte position out of range");

    // every CRC check bumps exactly one of the two frame counters
    a_one_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CHECK |=>
            32'(good_reg + bad_reg) == 32'($past(good_reg) + $past(bad_reg) + 32'd1))
        else $error("frame counters not advanced by one");

    // the frame's final result carries the highest channel index
    a_last_ch: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tdata[2:0] == 3'(CHANNELS - 1))
        else $error("last result on wrong channel");

endmodule

/* bench/adc_frame_crc_checker_test.sv */
// Self-checking bench for the ADC frame CRC checker: byte stream in, channel reports out.
module adc_frame_crc_checker_test;

    localparam int NCH         = adcfcc_pkg::CHANNELS_DEF;
    localparam int QUIET_LIMIT = 4000;  // cycles with no word moving on any port
    localparam int LONG_STALL  = 500;   // receiver hold-off, long enough to back up the block
    localparam int SETTLE      = 20;    // idle cycles before a register write
    localparam int TAIL        = 200;   // wait covering the CRC walk, the check and NCH reports, with margin
    localparam int PHASE_BYTES = 26;

    // one received byte as it travels on the input stream
    typedef struct {
        logic [7:0] rx_byte;
        logic       frame_start;
    } adc_byte_t;

    // one per-channel report at frame end
    typedef struct {
        logic [2:0]         channel;
        logic signed [15:0] sample_a;
        logic signed [15:0] sample_b;
        logic               data_valid;
        logic [31:0]        good_frames;
        logic [31:0]        bad_frames;
        logic               last;
    } channel_report_t;

    typedef logic [15:0] word_row_t [NCH];

    typedef enum logic [1:0] {
        FRAME_GOOD,
        FRAME_BAD_CRC,
        FRAME_CUT,
        FRAME_NOISE
    } frame_kind_t;

    logic                   clk;
    logic                   rst_n    = 1'b0;
    logic                   wr_en    = 1'b0;
    logic [0:0]             wr_index = '0;
    logic [2:0]             wr_data  = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [7:0]             s_tdata  = '0;  // [7:0] rx_byte
    logic [0:0]             s_tuser  = '0;  // [0] frame_start
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    // [2:0] channel, [18:3] sample_a, [34:19] sample_b, [66:35] good_frames,
    // [98:67] bad_frames, rest zero
    logic [adcfcc_pkg::OUT_TDATA_W-1:0] m_tdata;
    logic [0:0]             m_tuser;  // [0] data_valid
    logic                   m_tlast;

    adc_frame_crc_checker #(
        .CHANNELS (NCH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // stimulus waiting for the driver, reports waiting for the DUT
    adc_byte_t       byte_stream[$];
    channel_report_t channel_reports_due[$];

    int error_count = 0;
    int bytes_made  = 0;
    int quiet_cycles = 0;

    // idle percentages, changed by the sequencer at a falling edge only
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;

    // long receiver hold-off: sequencer bumps the request, ready process serves it
    int stall_requests = 0;
    int stalls_granted = 0;
    int stall_left     = 0;

    // predictor state, mirrors the DUT after every accepted word
    logic [2:0]  cfg_last = adcfcc_pkg::LAST_CHANNEL_RST;
    logic        cfg_crc  = adcfcc_pkg::CRC_MODE_RST;
    logic [5:0]  frame_pos = '0;
    word_row_t   pend_a = '{default: '0};
    word_row_t   pend_b = '{default: '0};
    word_row_t   pub_a  = '{default: '0};
    word_row_t   pub_b  = '{default: '0};
    logic        frame_good = 1'b0;
    logic [31:0] good_total = '0;
    logic [31:0] bad_total  = '0;

    // settings of the random phases: last_channel 7 in both modes, 0 in plain mode
    logic [2:0] phase_last [9] = '{3'd7, 3'd2, 3'd7, 3'd0, 3'd4, 3'd7, 3'd1, 3'd6, 3'd3};
    logic       phase_crc  [9] = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // CRC-8, poly 0x07, init 0: all A words then all B words, MSB first
    function automatic logic [7:0] crc8_of_words(input word_row_t wa, input word_row_t wb);
        logic [7:0]  crc;
        logic [15:0] w;
        logic        fb;
        crc = 8'h00;
        for (int i = 0; i < 2 * NCH; i++)
        begin
            w = (i < NCH) ? wa[i] : wb[i - NCH];
            for (int k = 15; k >= 0; k--)
            begin
                fb  = crc[7] ^ w[k];
                crc = {crc[6:0], 1'b0} ^ (fb ? adcfcc_pkg::CRC_POLY : 8'h00);
            end
        end
        return crc;
    endfunction

    function automatic void note_error(input string msg);
        error_count++;
        if (error_count <= 10)
            $display("%0t: %s", $realtime, msg);
    endfunction

    function automatic void check_field(input string what, input int ch,
                                        input logic [63:0] want, input logic [63:0] got);
        if (want !== got)
            note_error($sformatf("ch %0d %s: expected %0h, got %0h", ch, what, want, got));
    endfunction

    // Advance the frame tracker by one accepted byte; at frame end queue one
    // report per channel.
    task automatic track_frame_byte(input logic [7:0] rx, input logic fs);
        int              data_len;
        int              end_pos;
        int              ch;
        int              off;
        bit              high;
        logic [15:0]     w;
        channel_report_t r;
        data_len = 4 * (int'(cfg_last) + 1);
        end_pos  = cfg_crc ? data_len : data_len - 1;
        if (fs)
            frame_pos = '0;
        if (frame_pos == 0)
        begin
            pend_a = '{default: '0};
            pend_b = '{default: '0};
        end
        if (int'(frame_pos) < data_len)
        begin
            ch  = int'(frame_pos) >> 2;
            off = int'(frame_pos) & 3;
            if (ch < NCH)
            begin
                // byte order follows the mode in force when the byte arrives
                high = cfg_crc ? (off % 2 == 1) : (off % 2 == 0);
                w    = (off < 2) ? pend_a[ch] : pend_b[ch];
                if (high)
                    w[15:8] = rx;
                else
                    w[7:0] = rx;
                if (off < 2)
                    pend_a[ch] = w;
                else
                    pend_b[ch] = w;
            end
        end
        if (int'(frame_pos) < end_pos)
        begin
            frame_pos = frame_pos + 6'd1;
            return;
        end
        // frame end: a CRC byte in CRC mode, the last data byte in plain mode
        frame_pos = '0;
        if (cfg_crc)
        begin
            if (crc8_of_words(pend_a, pend_b) == rx)
            begin
                // a match takes every channel, so unscanned ones drop to zero
                pub_a      = pend_a;
                pub_b      = pend_b;
                frame_good = 1'b1;
                good_total = good_total + 32'd1;
            end
            else
            begin
                frame_good = 1'b0;
                bad_total  = bad_total + 32'd1;
            end
        end
        else
        begin
            // plain mode: unscanned channels keep what they had
            for (int i = 0; i <= int'(cfg_last) && i < NCH; i++)
            begin
                pub_a[i] = pend_a[i];
                pub_b[i] = pend_b[i];
            end
            frame_good = 1'b1;
        end
        for (int i = 0; i < NCH; i++)
        begin
            r.channel     = 3'(i);
            r.sample_a    = pub_a[i];
            r.sample_b    = pub_b[i];
            r.data_valid  = frame_good;
            r.good_frames = good_total;
            r.bad_frames  = bad_total;
            r.last        = (i == NCH - 1);
            channel_reports_due.push_back(r);
        end
    endtask

    // ------------------------------------------------------------------
    // Input driver: a new word only once the previous one has been taken.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        adc_byte_t item;
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (!s_tvalid || s_tready)
        begin
            if (byte_stream.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct)
            begin
                item = byte_stream.pop_front();
                s_tvalid   <= 1'b1;
                s_tdata    <= item.rx_byte;
                s_tuser[0] <= item.frame_start;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Receiver ready: random gaps, plus a long hold-off on request.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (stall_requests != stalls_granted)
            begin
                stalls_granted = stalls_granted + 1;
                stall_left     = LONG_STALL;
            end
            if (stall_left > 0)
            begin
                stall_left = stall_left - 1;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // predictor runs on every accepted input word
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            track_frame_byte(s_tdata, s_tuser[0]);
    end

    // ------------------------------------------------------------------
    // Report checker: each accepted output word against the oldest expectation.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        channel_report_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (channel_reports_due.size() == 0)
                note_error($sformatf("unexpected report word %0h", m_tdata));
            else
            begin
                want = channel_reports_due.pop_front();
                check_field("channel", want.channel, {61'b0, want.channel},
                            64'(m_tdata[2:0]));
                check_field("sample_a", want.channel, {48'b0, want.sample_a},
                            64'(m_tdata[18:3]));
                check_field("sample_b", want.channel, {48'b0, want.sample_b},
                            64'(m_tdata[34:19]));
                check_field("good_frames", want.channel, {32'b0, want.good_frames},
                            64'(m_tdata[66:35]));
                check_field("bad_frames", want.channel, {32'b0, want.bad_frames},
                            64'(m_tdata[98:67]));
                check_field("pad", want.channel, 64'd0,
                            64'(m_tdata[adcfcc_pkg::OUT_TDATA_W-1:adcfcc_pkg::OUT_FIELDS_W]));
                check_field("data_valid", want.channel, {63'b0, want.data_valid},
                            64'(m_tuser[0]));
                check_field("last", want.channel, {63'b0, want.last}, 64'(m_tlast));
            end
        end
    end

    // watchdog: too long without any word moving means the DUT is hung
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || wr_en)
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic push_byte(input logic [7:0] b, input logic fs);
        adc_byte_t item;
        item.rx_byte     = b;
        item.frame_start = fs;
        byte_stream.push_back(item);
        bytes_made++;
    endtask

    // 16-bit extremes two times in three, else a random sample
    function automatic logic [15:0] pick_sample();
        case ($urandom_range(0, 5))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'h8000;
            3:       return 16'h7FFF;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // Queue one frame for the current settings. Good and bad frames are whole,
    // a cut frame stops short (the next frame_start restarts), noise is a few
    // loose bytes with random frame_start.
    task automatic add_frame(input frame_kind_t kind, input bit fixed,
                             input logic [15:0] a_fix, input logic [15:0] b_fix);
        word_row_t   wa;
        word_row_t   wb;
        int          n_data;
        int          keep;
        int          nb;
        logic [15:0] w;
        logic [7:0]  crc_byte;
        wa = '{default: '0};
        wb = '{default: '0};
        if (kind == FRAME_NOISE)
        begin
            repeat ($urandom_range(1, 6))
                push_byte(8'($urandom_range(0, 255)), ($urandom_range(0, 3) == 0));
            return;
        end
        for (int ch = 0; ch <= int'(cfg_last); ch++)
        begin
            wa[ch] = fixed ? a_fix : pick_sample();
            wb[ch] = fixed ? b_fix : pick_sample();
        end
        n_data = 4 * (int'(cfg_last) + 1);
        keep   = (kind == FRAME_CUT) ? $urandom_range(1, n_data - 1) : n_data;
        nb     = 0;
        for (int ch = 0; ch <= int'(cfg_last); ch++)
        begin
            for (int half = 0; half < 2; half++)
            begin
                w = half ? wb[ch] : wa[ch];
                // CRC mode little-endian, plain mode big-endian
                if (nb < keep)
                    push_byte(cfg_crc ? w[7:0] : w[15:8], nb == 0);
                nb++;
                if (nb < keep)
                    push_byte(cfg_crc ? w[15:8] : w[7:0], 1'b0);
                nb++;
            end
        end
        if (cfg_crc && kind != FRAME_CUT)
        begin
            crc_byte = crc8_of_words(wa, wb);
            if (kind == FRAME_BAD_CRC)
                crc_byte = crc_byte ^ 8'($urandom_range(1, 255));
            push_byte(crc_byte, 1'b0);
        end
    endtask

    // all queued words taken and every due report received
    task automatic wait_drained();
        do
            @(negedge clk);
        while (byte_stream.size() != 0 || s_tvalid || channel_reports_due.size() != 0);
    endtask

    // register write on an idle block; predictor settings follow at the write edge
    task automatic set_register(input logic [0:0] idx, input logic [2:0] value);
        repeat (SETTLE) @(posedge clk);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= value;
        @(posedge clk);
        wr_en <= 1'b0;
        case (idx)
            adcfcc_pkg::REG_LAST_CHANNEL: cfg_last = value;
            adcfcc_pkg::REG_CRC_MODE:     cfg_crc  = value[0];
            default:                      ;
        endcase
        @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // Sequencer: directed frames, then random phases over several settings.
    // ------------------------------------------------------------------
    initial
    begin
        int          target;
        int          roll;
        frame_kind_t kind;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        tx_idle_pct = 21;
        rx_idle_pct = 51;

        // Reset settings (all 8 channels, CRC mode): five bytes must not end a
        // frame. Then last_channel drops to 0 mid-frame, so the next byte sits
        // past the end and is taken as the CRC byte.
        push_byte(8'hFF, 1'b1);
        push_byte(8'h00, 1'b0);
        push_byte(8'h80, 1'b0);
        push_byte(8'h7F, 1'b0);
        push_byte(8'h01, 1'b0);
        wait_drained();
        set_register(adcfcc_pkg::REG_LAST_CHANNEL, 3'd0);
        push_byte(8'h5A, 1'b0);

        // one channel: matching CRC, mismatching CRC, restart by frame_start
        add_frame(FRAME_GOOD, 1'b1, 16'h7FFF, 16'h8000);
        add_frame(FRAME_BAD_CRC, 1'b1, 16'hFFFF, 16'h0000);
        push_byte(8'h11, 1'b1);
        push_byte(8'h22, 1'b0);
        add_frame(FRAME_GOOD, 1'b1, 16'h0000, 16'hFFFF);

        // plain mode, big-endian, no CRC byte
        wait_drained();
        set_register(adcfcc_pkg::REG_CRC_MODE, 3'd0);
        add_frame(FRAME_GOOD, 1'b1, 16'h8001, 16'h7FFE);

        for (int p = 0; p < 9; p++)
        begin
            wait_drained();
            set_register(adcfcc_pkg::REG_LAST_CHANNEL, phase_last[p]);
            set_register(adcfcc_pkg::REG_CRC_MODE, {2'b00, phase_crc[p]});
            if (p < 3)
            begin
                tx_idle_pct = 21;
                rx_idle_pct = 51;
            end
            else if (p < 6)
            begin
                tx_idle_pct = 51;
                rx_idle_pct = 21;
            end
            else
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            // receiver goes away while the sender keeps offering words
            if (p == 4)
                stall_requests = stall_requests + 1;
            target = bytes_made + PHASE_BYTES;
            while (bytes_made < target)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 60)
                    kind = FRAME_GOOD;
                else if (roll < 75)
                    kind = FRAME_BAD_CRC;
                else if (roll < 87)
                    kind = FRAME_CUT;
                else
                    kind = FRAME_NOISE;
                add_frame(kind, 1'b0, 16'h0000, 16'h0000);
            end
        end

        wait_drained();
        repeat (TAIL) @(posedge clk);
        if (error_count == 0 && channel_reports_due.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/adcfcc_pkg.sv
hw/rtl/adc_frame_crc_checker.sv
bench/adc_frame_crc_checker_test.sv
